/* src/smm_pkg.sv */
package smm_pkg;

    // fixed field widths
    localparam int MODE_W     = 2;
    localparam int IDX_FLD_W  = 3;
    localparam int VAL_W      = 16;
    localparam int MUL_W      = 2 * VAL_W;
    localparam int PROD_W     = 35;
    localparam int SIZE_W     = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    // size register value after reset
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // input beat kinds
    localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_OUT
    } t_smm_state;

endpackage

/* src/smm_ram.sv */
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* src/square_matrix_multiply.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata row,col,value; tuser mode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata out_row,out_col,product; tlast
// cfg       in   i_cfg_valid / o_cfg_ready      size_in_use
//
// a load beat writes one store entry; a compute beat runs every term of every element
// through the single shared multiplier, fed one A and one B element a cycle from the
// two store read ports while the sequencer issues, then drains and emits each element
// a stalled output holds the sequencer in its emit step until the beat is taken
// synchronous active-low reset clears control; the stores are not cleared
module square_matrix_multiply #(
    parameter int MAX_DIM = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smm_pkg::SIZE_W-1:0]        i_cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [smm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // row[2:0], col[5:3], value[21:6]
    input  logic [smm_pkg::MODE_W-1:0]        s_axis_tuser,  // mode[1:0]
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [smm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // out_row[2:0], out_col[5:3], product[40:6]
    output logic                              m_axis_tlast
);

    import smm_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int IDX_W  = $clog2(MAX_DIM > 1 ? MAX_DIM : 2);

    t_smm_state r_state, n_state;

    logic [SIZE_W-1:0]   r_size;
    logic [IDX_W-1:0]    r_last_idx;
    logic [IDX_W-1:0]    r_i, r_j, r_k;
    logic                r_v1, r_l1, r_v2, r_l2;
    logic signed [MUL_W-1:0] r_mul;
    logic [PROD_W-1:0]   r_acc;

    logic                r_ov, r_olast;
    logic [IDX_FLD_W-1:0] r_orow, r_ocol;
    logic [PROD_W-1:0]   r_oprod;

    logic [IDX_FLD_W-1:0] in_row, in_col;
    logic [VAL_W-1:0]    in_val;
    logic                in_beat, wr_ok, we_a, we_b, start;
    logic [ADDR_W-1:0]   waddr, raddr_a, raddr_b;
    logic [VAL_W-1:0]    rdata_a, rdata_b;
    logic                k_last, j_last, i_last, out_load;
    logic [IDX_W-1:0]    dim_last;

    // unpack input beat
    assign in_row  = s_axis_tdata[2:0];
    assign in_col  = s_axis_tdata[5:3];
    assign in_val  = s_axis_tdata[21:6];
    assign in_beat = s_axis_tvalid && s_axis_tready;

    // writes outside the built store are dropped
    assign wr_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
    assign waddr = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));
    assign we_a  = in_beat && (s_axis_tuser == MODE_WR_A) && wr_ok;
    assign we_b  = in_beat && (s_axis_tuser == MODE_WR_B) && wr_ok;
    assign start = in_beat && (s_axis_tuser == MODE_COMPUTE);

    // read addresses for the current term
    assign raddr_a = ADDR_W'(int'(r_i) * MAX_DIM + int'(r_k));
    assign raddr_b = ADDR_W'(int'(r_k) * MAX_DIM + int'(r_j));

    assign k_last = (r_k == r_last_idx);
    assign j_last = (r_j == r_last_idx);
    assign i_last = (r_i == r_last_idx);

    // saturate the size register into a last index
    always_comb begin
        priority if (r_size == '0) begin
            dim_last = '0;
        end else if (int'(r_size) > MAX_DIM) begin
            dim_last = IDX_W'(MAX_DIM - 1);
        end else begin
            dim_last = IDX_W'(int'(r_size) - 1);
        end
    end

    smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (in_val),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    smm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (in_val),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // size register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_size <= i_cfg_data;
        end
    end

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (start) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_v2 && r_l2) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ov || m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = (i_last && j_last) ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
            r_k <= '0;
            r_last_idx <= '0;
        end else begin
            if (start) begin
                r_i <= '0;
                r_j <= '0;
                r_k <= '0;
                r_last_idx <= dim_last;
            end
            if (r_state == S_ISSUE) begin
                r_k <= k_last ? '0 : r_k + 1'b1;
            end
            if (out_load) begin
                if (j_last) begin
                    r_j <= '0;
                    r_i <= r_i + 1'b1;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end
        end
    end

    // term pipeline flags: read, multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_l1 <= 1'b0;
            r_v2 <= 1'b0;
            r_l2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_ISSUE);
            r_l1 <= (r_state == S_ISSUE) && k_last;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
        end
    end

    // shared multiplier
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_mul <= $signed(rdata_a) * $signed(rdata_b);
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (start || out_load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(PROD_W-MUL_W){r_mul[MUL_W-1]}}, r_mul};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_orow  <= IDX_FLD_W'(r_i);
            r_ocol  <= IDX_FLD_W'(r_j);
            r_oprod <= r_acc;
            r_olast <= i_last && j_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {{(OUT_DATA_W-PROD_W-2*IDX_FLD_W){1'b0}}, r_oprod, r_ocol, r_orow};

endmodule

/* src/smm_checker.sv */
module smm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [smm_pkg::MODE_W-1:0]        s_axis_tuser,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [smm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              m_axis_tlast
);

    import smm_pkg::*;

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output beat changed");

    // a compute beat makes the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_COMPUTE) |=> !s_axis_tready)
        else $error("input ready straight after compute beat");

    // the last element sits on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[2:0] == m_axis_tdata[5:3]))
        else $error("last element off the diagonal");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind square_matrix_multiply smm_checker u_smm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb_square_matrix_multiply.sv */
module tb_square_matrix_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import smm_pkg::*;

    localparam int DIM_MAX = 8;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int BURST_STALL_CYCLES = 1500;

    typedef enum logic {
        STEP_CFG,
        STEP_BEAT
    } t_step_kind;

    typedef struct {
        t_step_kind        kind;
        logic [SIZE_W-1:0] size;
        logic [MODE_W-1:0] mode;
        logic [2:0]        row_idx;
        logic [2:0]        col_idx;
        logic [15:0]       value;
        bit                typed;
        logic signed [34:0] typed_prod;
    } t_stim_row;

    typedef struct {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [34:0] product;
        logic               last;
    } t_product_beat;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [SIZE_W-1:0]      i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;  // row[2:0], col[5:3], value[21:6]
    logic [MODE_W-1:0]      s_axis_tuser = '0;  // mode[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;       // out_row[2:0], out_col[5:3], product[40:6]
    logic                   m_axis_tlast;

    // travels with each input beat so the monitor sees the typed-in expectation
    bit                     typed_row = 1'b0;
    logic signed [34:0]     typed_product = '0;

    // idling and burst stall control
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    bit                     burst_armed = 1'b0;
    bit                     burst_done = 1'b0;
    int                     hold_left = 0;

    // predictor state
    logic signed [15:0]     a_store [0:DIM_MAX*DIM_MAX-1];
    logic signed [15:0]     b_store [0:DIM_MAX*DIM_MAX-1];
    logic [SIZE_W-1:0]      size_reg = SIZE_RESET;
    t_product_beat          expected_q[$];

    int                     fail_count = 0;
    int                     beats_in = 0;
    int                     computes_seen = 0;
    int                     beats_checked = 0;

    t_stim_row              directed_rows[$];

    square_matrix_multiply #(
        .MAX_DIM(DIM_MAX)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // dimension in use for a given size register value
    function automatic int active_dim(logic [SIZE_W-1:0] s);
        if (s == 0) begin
            return 1;
        end
        if (s > DIM_MAX) begin
            return DIM_MAX;
        end
        return int'(s);
    endfunction

    // update stores or queue the whole product for one accepted beat
    function automatic void predict_beat(logic [MODE_W-1:0] mode, logic [2:0] r,
                                         logic [2:0] c, logic [15:0] v, bit typed,
                                         logic signed [34:0] tprod);
        int n;
        longint acc;
        t_product_beat elem;
        case (mode)
            MODE_WR_A: begin
                a_store[r*DIM_MAX+c] = v;
            end
            MODE_WR_B: begin
                b_store[r*DIM_MAX+c] = v;
            end
            MODE_COMPUTE: begin
                n = active_dim(size_reg);
                computes_seen++;
                for (int i = 0; i < n; i++) begin
                    for (int j = 0; j < n; j++) begin
                        acc = 0;
                        for (int k = 0; k < n; k++) begin
                            acc += longint'(a_store[i*DIM_MAX+k]) *
                                   longint'(b_store[k*DIM_MAX+j]);
                        end
                        elem.out_row = i[2:0];
                        elem.out_col = j[2:0];
                        elem.product = typed ? tprod : acc[34:0];
                        elem.last = (i == n - 1) && (j == n - 1);
                        expected_q.push_back(elem);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // compare one product beat with the oldest expectation
    task automatic check_product_beat();
        t_product_beat exp_beat;
        logic [2:0] got_row;
        logic [2:0] got_col;
        logic signed [34:0] got_prod;
        got_row = m_axis_tdata[2:0];
        got_col = m_axis_tdata[5:3];
        got_prod = m_axis_tdata[40:6];
        if (expected_q.size() == 0) begin
            $error("unexpected product beat: row %0d col %0d product %0d",
                   got_row, got_col, got_prod);
            fail_count++;
        end else begin
            exp_beat = expected_q.pop_front();
            beats_checked++;
            if (got_row !== exp_beat.out_row) begin
                $error("out_row mismatch: expected %0d, got %0d", exp_beat.out_row, got_row);
                fail_count++;
            end
            if (got_col !== exp_beat.out_col) begin
                $error("out_col mismatch: expected %0d, got %0d", exp_beat.out_col, got_col);
                fail_count++;
            end
            if (got_prod !== exp_beat.product) begin
                $error("product mismatch: expected %0d, got %0d", exp_beat.product, got_prod);
                fail_count++;
            end
            if (m_axis_tlast !== exp_beat.last) begin
                $error("last mismatch: expected %0d, got %0d", exp_beat.last, m_axis_tlast);
                fail_count++;
            end
        end
    endtask

    // handshake monitor: register writes, input beats, product beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                size_reg = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beats_in++;
                predict_beat(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[5:3],
                             s_axis_tdata[21:6], typed_row, typed_product);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_product_beat();
            end
        end
    end

    // receiver: random backpressure plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (burst_armed && !burst_done && m_axis_tvalid) begin
            hold_left <= BURST_STALL_CYCLES;
            burst_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // run time limit
    initial begin
        #50_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic void add_cfg(logic [SIZE_W-1:0] s);
        t_stim_row ent;
        ent = '{kind: STEP_CFG, default: '0};
        ent.size = s;
        directed_rows.push_back(ent);
    endfunction

    function automatic void add_beat(logic [MODE_W-1:0] mode, logic [2:0] r, logic [2:0] c,
                                     logic [15:0] v, bit typed, logic signed [34:0] tprod);
        t_stim_row ent;
        ent = '{kind: STEP_BEAT, default: '0};
        ent.mode = mode;
        ent.row_idx = r;
        ent.col_idx = c;
        ent.value = v;
        ent.typed = typed;
        ent.typed_prod = tprod;
        directed_rows.push_back(ent);
    endfunction

    // offer one input beat, with a random gap before it
    task automatic offer_item(logic [MODE_W-1:0] mode, logic [2:0] r, logic [2:0] c,
                              logic [15:0] v, bit typed, logic signed [34:0] tprod);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v, c, r};
        s_axis_tuser <= mode;
        typed_row <= typed;
        typed_product <= tprod;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // let every expected product beat arrive, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // size register write, only once the block is idle
    task automatic write_size(logic [SIZE_W-1:0] s);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // fill every entry of A, and of B if asked, with one value
    task automatic load_matrices(logic [15:0] a_val, logic [15:0] b_val, bit with_b);
        for (int r = 0; r < DIM_MAX; r++) begin
            for (int c = 0; c < DIM_MAX; c++) begin
                offer_item(MODE_WR_A, r[2:0], c[2:0], a_val, 1'b0, '0);
                if (with_b) begin
                    offer_item(MODE_WR_B, r[2:0], c[2:0], b_val, 1'b0, '0);
                end
            end
        end
    endtask

    // stimulus
    initial begin
        t_stim_row ent;
        logic [SIZE_W-1:0] phase_size[$];
        logic [MODE_W-1:0] mode;
        logic [2:0] r;
        logic [2:0] c;
        logic [15:0] v;
        int n;
        int pick;
        int wait_cycles;

        phase_size = '{4'd8, 4'd3, 4'd15, 4'd5, 4'd0, 4'd2, 4'd9, 4'd1, 4'd7};

        // directed rows: corner values at small sizes, typed where obvious
        add_cfg(4'd1);
        add_beat(MODE_WR_A, 3'd0, 3'd0, 16'h8000, 1'b0, '0);
        add_beat(MODE_WR_B, 3'd0, 3'd0, 16'h8000, 1'b0, '0);
        add_beat(MODE_UNUSED, 3'd7, 3'd7, 16'hFFFF, 1'b0, '0);
        add_beat(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'sd1073741824);
        add_beat(MODE_WR_A, 3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        add_beat(MODE_COMPUTE, 3'd7, 3'd7, 16'hFFFF, 1'b1, -35'sd1073709056);
        // size register zero behaves as one
        add_cfg(4'd0);
        add_beat(MODE_WR_B, 3'd0, 3'd0, 16'h7FFF, 1'b0, '0);
        add_beat(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'sd1073676289);
        add_cfg(4'd2);
        for (int i = 0; i < 4; i++) begin
            add_beat(MODE_WR_A, 3'(i >> 1), 3'(i & 1), 16'h8000, 1'b0, '0);
            add_beat(MODE_WR_B, 3'(i >> 1), 3'(i & 1), 16'h8000, 1'b0, '0);
        end
        add_beat(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b1, 35'sd2147483648);
        // writes outside the size in use are kept for later
        add_beat(MODE_WR_A, 3'd7, 3'd7, 16'h5555, 1'b0, '0);
        add_beat(MODE_WR_B, 3'd7, 3'd7, 16'hAAAA, 1'b0, '0);
        add_beat(MODE_WR_A, 3'd1, 3'd0, 16'h0000, 1'b0, '0);
        add_beat(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
        add_beat(MODE_UNUSED, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
        add_beat(MODE_COMPUTE, 3'd5, 3'd2, 16'h1234, 1'b0, '0);

        // reset
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct <= 61;
        foreach (directed_rows[i]) begin
            ent = directed_rows[i];
            if (ent.kind == STEP_CFG) begin
                write_size(ent.size);
            end else begin
                offer_item(ent.mode, ent.row_idx, ent.col_idx, ent.value,
                           ent.typed, ent.typed_prod);
            end
        end

        // random phases, one size setting each
        foreach (phase_size[p]) begin
            if (p < 3) begin
                send_idle_pct = 10;
                recv_idle_pct <= 61;
            end else if (p < 6) begin
                send_idle_pct = 61;
                recv_idle_pct <= 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            burst_armed <= (p == 6);
            write_size(phase_size[p]);
            n = active_dim(phase_size[p]);

            // full fills give the largest and the smallest possible sums
            if (p == 0) begin
                load_matrices(16'h8000, 16'h8000, 1'b1);
                offer_item(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
                load_matrices(16'h7FFF, 16'h0000, 1'b0);
                offer_item(MODE_COMPUTE, 3'd0, 3'd0, 16'h0000, 1'b0, '0);
            end

            for (int it = 0; it < 30; it++) begin
                pick = $urandom_range(99);
                r = 3'($urandom_range(7));
                c = 3'($urandom_range(7));
                v = 16'($urandom);
                if (pick < ((p == 6) ? 30 : 12)) begin
                    mode = MODE_COMPUTE;
                end else if (pick < 40 && p != 6) begin
                    mode = MODE_UNUSED;
                    if (pick >= 16) begin
                        mode = $urandom_range(1) ? MODE_WR_A : MODE_WR_B;
                    end
                end else begin
                    mode = $urandom_range(1) ? MODE_WR_A : MODE_WR_B;
                end
                if (mode == MODE_WR_A || mode == MODE_WR_B) begin
                    // mostly inside the size in use so the next product moves
                    if ($urandom_range(3) != 0) begin
                        r = 3'($urandom_range(n - 1));
                        c = 3'($urandom_range(n - 1));
                    end
                    case ($urandom_range(7))
                        0: v = 16'h8000;
                        1: v = 16'h7FFF;
                        2: v = ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
                        default: begin
                        end
                    endcase
                end
                offer_item(mode, r, c, v, 1'b0, '0);
            end
            offer_item(MODE_COMPUTE, 3'($urandom_range(7)), 3'($urandom_range(7)),
                       16'($urandom), 1'b0, '0);
        end

        // drain with a bound
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        for (wait_cycles = 0; expected_q.size() != 0 && wait_cycles < 200000;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (expected_q.size() != 0) begin
            $error("%0d product beats never arrived", expected_q.size());
            fail_count++;
        end

        $display("covered %0d input beats with %0d computes over sizes 0 to 15",
                 beats_in, computes_seen);
        $display("checked %0d product beats, one %0d-cycle output stall included",
                 beats_checked, BURST_STALL_CYCLES);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* square_matrix_multiply.f */
src/smm_pkg.sv
src/smm_ram.sv
src/square_matrix_multiply.sv
src/smm_checker.sv
sim/tb_square_matrix_multiply.sv
